// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Property that must hold whenever the antecedent holds.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- design/bslr_pkg.sv -----
package bslr_pkg;

    // Default ring depth
    localparam int MAX_SLOTS_DEF = 4;

    // Width of slot_count, next pointer and scan pointer
    localparam int CNT_W = 3;

    // Action codes
    localparam logic [2:0] ACT_ACQUIRE    = 3'd0;
    localparam logic [2:0] ACT_HAND_OVER  = 3'd1;
    localparam logic [2:0] ACT_GIVE_BACK  = 3'd2;
    localparam logic [2:0] ACT_FRAME_DONE = 3'd3;
    localparam logic [2:0] ACT_MARK_STALE = 3'd4;
    localparam logic [2:0] ACT_REBUILD    = 3'd5;

    // One request
    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  slot_index;
        logic [63:0] frame_tag;
        logic [3:0]  lock_free_mask;
    } req_t;

    // One result
    typedef struct packed {
        logic       ok;
        logic [1:0] granted_index;
        logic [2:0] busy_count;
        logic       is_stale;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic cfg_we;   // write slot_count, clear ring
        logic load;     // capture request, arm scan
        logic exec;     // apply a non-scanning action
        logic scan;     // advance scan pointer
        logic grant;    // lease the slot under the scan pointer
        logic finish;   // load result, raise done next cycle
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_mode;   // captured request is an acquire that may scan
        logic hit;         // slot under scan pointer is grantable
        logic last;        // scan pointer is on the last slot to try
    } sts_t;

endpackage

// ----- design/bslr_ctrl.sv -----
`include "assert_macros.svh"

module bslr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           cfg_valid,
    output logic           busy,
    output logic           cfg_ready,
    output bslr_pkg::cmd_t cmd,
    input  bslr_pkg::sts_t sts
);
    import bslr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    // State update issued this cycle
    logic upd_cycle;

    // Sequencing: an action is applied from EXEC; a scanning acquire stays in EXEC until a grant or the last slot
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // a pending request goes first; the register write waits for the next idle cycle
                cmd.cfg_we = cfg_valid && !start;
                cmd.load   = start;
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!sts.scan_mode)
                begin
                    cmd.exec   = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (sts.hit)
                begin
                    cmd.grant  = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (sts.last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !start;
    assign upd_cycle = cmd.exec || cmd.grant;

    `ASSERT_IMPLY(a_busy_from_start, clk, rst_n, $rose(busy), $past(start), "busy without request")
    `ASSERT_IMPLY(a_one_update, clk, rst_n, upd_cycle, cmd.finish && !cmd.scan, "stray update")

endmodule

// ----- design/bslr_dp.sv -----
`include "assert_macros.svh"

module bslr_dp #(
    parameter int MAX_SLOTS = bslr_pkg::MAX_SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bslr_pkg::cmd_t              cmd,
    output bslr_pkg::sts_t              sts,
    input  bslr_pkg::req_t              req,
    input  logic [bslr_pkg::CNT_W-1:0]  cfg_data,
    output bslr_pkg::rsp_t              rsp,
    output logic                        done
);
    import bslr_pkg::*;

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SUM_W  = $clog2(MAX_SLOTS + 1);

    // Request and scan registers
    req_t             req_reg;
    logic [CNT_W-1:0] scan_ptr_reg;
    logic [CNT_W-1:0] scan_cnt_reg;

    // Ring state
    logic [MAX_SLOTS-1:0] leased_reg,  leased_next;
    logic [MAX_SLOTS-1:0] owned_reg,   owned_next;
    logic [63:0]          tag_reg [MAX_SLOTS];
    logic [CNT_W-1:0]     next_slot_reg, next_slot_next;
    logic                 stale_reg,   stale_next;
    logic [CNT_W-1:0]     count_reg,   count_next;

    // Result registers
    logic       ok_reg;
    logic [1:0] granted_reg;
    logic       done_reg;

    logic [SLOT_W-1:0]    req_idx;
    logic [SLOT_W-1:0]    scan_idx;
    logic                 in_range;
    logic                 tag_match;
    logic                 hand_ok;
    logic                 exec_ok;
    logic [CNT_W-1:0]     scan_ptr_inc;
    logic [CNT_W-1:0]     cfg_sat;
    logic [MAX_SLOTS-1:0] in_use;
    logic [SUM_W-1:0]     busy_sum;

    assign req_idx  = SLOT_W'(req_reg.slot_index);
    assign scan_idx = SLOT_W'(scan_ptr_reg);

    // Index checks for the named slot
    assign in_range  = (count_reg != '0) && ({1'b0, count_reg} > req_reg.slot_index);
    assign tag_match = (tag_reg[req_idx] == req_reg.frame_tag);
    assign hand_ok   = in_range && leased_reg[req_idx];

    // Saturated register write
    assign cfg_sat = (int'(cfg_data) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : cfg_data;

    // Ring pointer increment, wrapping at slot_count
    assign scan_ptr_inc = (scan_ptr_reg + 1'b1 == count_reg) ? '0 : scan_ptr_reg + 1'b1;

    // Scan status: only slots 0..3 carry a lock bit
    assign sts.scan_mode = (req_reg.action == ACT_ACQUIRE) && (count_reg != '0) && !stale_reg;
    assign sts.hit       = !scan_ptr_reg[2] && req_reg.lock_free_mask[scan_ptr_reg[1:0]]
                           && !leased_reg[scan_idx] && !owned_reg[scan_idx];
    assign sts.last      = (scan_cnt_reg == count_reg - 1'b1);

    // Next ring state
    always_comb
    begin
        leased_next    = leased_reg;
        owned_next     = owned_reg;
        next_slot_next = next_slot_reg;
        stale_next     = stale_reg;
        count_next     = count_reg;
        exec_ok        = 1'b0;
        case (req_reg.action)
            ACT_HAND_OVER:  exec_ok = hand_ok;
            ACT_GIVE_BACK:  exec_ok = hand_ok;
            ACT_FRAME_DONE: exec_ok = in_range && owned_reg[req_idx] && tag_match;
            ACT_MARK_STALE: exec_ok = (count_reg != '0);
            ACT_REBUILD:    exec_ok = 1'b1;
            default:        exec_ok = 1'b0;
        endcase
        if (cmd.cfg_we)
        begin
            leased_next    = '0;
            owned_next     = '0;
            next_slot_next = '0;
            stale_next     = 1'b0;
            count_next     = cfg_sat;
        end
        else if (cmd.exec && exec_ok)
        begin
            case (req_reg.action)
                ACT_HAND_OVER:
                begin
                    leased_next[req_idx] = 1'b0;
                    owned_next[req_idx]  = 1'b1;
                end
                ACT_GIVE_BACK:
                begin
                    leased_next[req_idx] = 1'b0;
                    owned_next[req_idx]  = 1'b0;
                end
                ACT_FRAME_DONE:
                begin
                    owned_next[req_idx] = 1'b0;
                end
                ACT_MARK_STALE:
                begin
                    stale_next = 1'b1;
                end
                ACT_REBUILD:
                begin
                    leased_next    = '0;
                    owned_next     = '0;
                    next_slot_next = '0;
                    stale_next     = 1'b0;
                    count_next     = '0;
                end
                default:
                begin
                    stale_next = stale_reg;
                end
            endcase
        end
        else if (cmd.grant)
        begin
            leased_next[scan_idx] = 1'b1;
            next_slot_next        = scan_ptr_inc;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leased_reg    <= '0;
            owned_reg     <= '0;
            next_slot_reg <= '0;
            stale_reg     <= 1'b0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            scan_ptr_reg  <= '0;
            scan_cnt_reg  <= '0;
        end
        else
        begin
            leased_reg    <= leased_next;
            owned_reg     <= owned_next;
            next_slot_reg <= next_slot_next;
            stale_reg     <= stale_next;
            count_reg     <= count_next;
            done_reg      <= cmd.finish;
            if (cmd.load)
            begin
                scan_ptr_reg <= next_slot_reg;
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan)
            begin
                scan_ptr_reg <= scan_ptr_inc;
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
        end
    end

    // Payload: request capture, tags, result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.exec && (req_reg.action == ACT_HAND_OVER) && hand_ok)
        begin
            tag_reg[req_idx] <= req_reg.frame_tag;
        end
        if (cmd.finish)
        begin
            ok_reg      <= cmd.exec ? exec_ok : cmd.grant;
            granted_reg <= cmd.grant ? scan_ptr_reg[1:0] : 2'd0;
        end
    end

    // Consumer-owned count over the slots in use
    always_comb
    begin
        busy_sum = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            in_use[i] = (i < int'(count_reg));
            busy_sum  = busy_sum + SUM_W'(owned_reg[i] && in_use[i]);
        end
    end

    assign rsp.ok            = ok_reg;
    assign rsp.granted_index = granted_reg;
    assign rsp.busy_count    = CNT_W'(busy_sum);
    assign rsp.is_stale      = stale_reg;
    assign done              = done_reg;

    `ASSERT_ALWAYS(a_one_owner, clk, rst_n, (leased_reg & owned_reg) == '0, "slot leased and owned at once")
    `ASSERT_ALWAYS(a_unused_clear, clk, rst_n, ((leased_reg | owned_reg) & ~in_use) == '0, "slot beyond slot_count in use")
    `ASSERT_ALWAYS(a_next_range, clk, rst_n, (count_reg == '0) ? (next_slot_reg == '0) : (next_slot_reg < count_reg), "next pointer out of ring")
    `ASSERT_IMPLY(a_grant_ok, clk, rst_n, done_reg && (granted_reg != 2'd0), ok_reg, "granted index without success")

endmodule

// ----- design/buffer_slot_lease_ring_top.sv -----
// Round-robin buffer slot pool. A request is taken when start is high and busy is low; its
// result appears on rsp while done is high for exactly one cycle. The request is registered, then
// applied in the EXEC state, and done is registered from its finish; an acquire on a non-empty,
// non-stale ring stays in EXEC and scans 1 to slot_count slots, examining one slot of the ring
// per cycle. A new request may be taken in the cycle that done is high. The receiver cannot
// stall: done is a single pulse and must be captured when it appears. busy_count and is_stale
// on rsp reflect the ring state after the action. slot_count is written through cfg_valid/cfg_ready
// while busy and start are low; the write also clears the ring.
module buffer_slot_lease_ring_top #(
    parameter int MAX_SLOTS = bslr_pkg::MAX_SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bslr_pkg::req_t              req,
    output logic                        done,
    output bslr_pkg::rsp_t              rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bslr_pkg::CNT_W-1:0]  cfg_data
);
    import bslr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    bslr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Ring state and result
    bslr_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .req      (req),
        .cfg_data (cfg_data),
        .rsp      (rsp),
        .done     (done)
    );

endmodule
